/* src/rpft_pkg.sv */
`default_nettype none

package rpft_pkg;

    // Field and register widths.
    localparam int unsigned NS_W     = 20;
    localparam int unsigned LINES_W  = 11;
    localparam int unsigned STAMP_W  = 63;
    localparam int unsigned FRAME_W  = NS_W + LINES_W;
    localparam int unsigned UNTIL_W  = 32;
    localparam int unsigned IDX_W    = 4;

    // Divider geometry: dividend shift register and step counter.
    localparam int unsigned DIVD_W   = 64;
    localparam int unsigned STEP_W   = 7;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_BITS   = LINES_W + NS_W + 5 + 2 * UNTIL_W;
    localparam int unsigned M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Request kinds carried in tuser.
    localparam logic CMD_QUERY   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_PIXEL_NS     = 4'd0,
        REG_HSYNC_START  = 4'd1,
        REG_HSYNC_END    = 4'd2,
        REG_LINE_NS      = 4'd3,
        REG_VACTIVE      = 4'd4,
        REG_VSYNC_START  = 4'd5,
        REG_VSYNC_END    = 4'd6,
        REG_FRAME_LINES  = 4'd7
    } t_reg_idx;

    // Timing configuration as seen by the datapath.
    typedef struct packed {
        logic [NS_W-1:0]    pixel_ns;
        logic [NS_W-1:0]    hsync_start_ns;
        logic [NS_W-1:0]    hsync_end_ns;
        logic [NS_W-1:0]    line_ns;
        logic [LINES_W-1:0] vactive_lines;
        logic [LINES_W-1:0] vsync_start_line;
        logic [LINES_W-1:0] vsync_end_line;
        logic [LINES_W-1:0] frame_lines;
    } t_cfg;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [STEP_W-1:0]  steps;
        logic [DIVD_W-1:0]  dividend;
        logic [FRAME_W-1:0] divisor;
    } t_div_req;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MOD_GO,
        S_MOD,
        S_LINE_GO,
        S_LINE,
        S_PIX_GO,
        S_PIX,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

/* src/rpft_regs.sv */
`default_nettype none

module rpft_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rpft_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rpft_pkg::NS_W-1:0]   i_cfg_data,
    output rpft_pkg::t_cfg                   o_cfg
);

    rpft_pkg::t_cfg r_cfg;

    // Register file; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (rpft_pkg::t_reg_idx'(i_cfg_idx))
                rpft_pkg::REG_PIXEL_NS:    r_cfg.pixel_ns         <= i_cfg_data;
                rpft_pkg::REG_HSYNC_START: r_cfg.hsync_start_ns   <= i_cfg_data;
                rpft_pkg::REG_HSYNC_END:   r_cfg.hsync_end_ns     <= i_cfg_data;
                rpft_pkg::REG_LINE_NS:     r_cfg.line_ns          <= i_cfg_data;
                rpft_pkg::REG_VACTIVE:
                    r_cfg.vactive_lines    <= i_cfg_data[rpft_pkg::LINES_W-1:0];
                rpft_pkg::REG_VSYNC_START:
                    r_cfg.vsync_start_line <= i_cfg_data[rpft_pkg::LINES_W-1:0];
                rpft_pkg::REG_VSYNC_END:
                    r_cfg.vsync_end_line   <= i_cfg_data[rpft_pkg::LINES_W-1:0];
                rpft_pkg::REG_FRAME_LINES:
                    r_cfg.frame_lines      <= i_cfg_data[rpft_pkg::LINES_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/rpft_div.sv */
`default_nettype none

module rpft_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rpft_pkg::t_div_req            i_req,
    output logic                               o_done,
    output logic [rpft_pkg::DIVD_W-1:0]        o_quot,
    output logic [rpft_pkg::FRAME_W-1:0]       o_rem
);

    localparam int unsigned RW = rpft_pkg::FRAME_W;
    localparam int unsigned QW = rpft_pkg::DIVD_W;

    logic                                r_busy;
    logic                                r_done;
    logic [rpft_pkg::STEP_W-1:0]         r_cnt;
    logic [RW-1:0]                       r_rem;
    logic [QW-1:0]                       r_quo;
    logic [RW-1:0]                       r_div;

    logic [RW:0]                         shifted;
    logic                                fits;
    logic [RW:0]                         diff;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem, r_quo[QW-1]};
        fits    = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - rpft_pkg::STEP_W'(1);
                if (r_cnt == rpft_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[RW-1:0] : shifted[RW-1:0];
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    // A completion is always the end of a running division.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

    // The remainder stays below a nonzero divisor through the iteration.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_div != '0) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    // A new division is never started over a running one.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    // A running division always has steps left.
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider running with no steps left");

endmodule

`default_nettype wire

/* src/raster_position_from_time.sv */
// Raster position from time. A request on the slave stream either restarts the
// dot clock at its stamp (tuser set) or asks for the raster position at its stamp
// (tuser clear). Every request yields exactly one result on the master stream;
// restarts, requests with the clock off, and requests while line_ns or frame_lines
// is zero give an all-zero result. A position query first uses one shared 20x11
// multiplier for the frame, vblank and vsync times, then runs three divisions
// through one shared radix-2 restoring divider at one quotient bit per cycle (63
// steps for the time within the frame, 31 for the line, 20 for the pixel), each
// with a launch state and a completion state, and then loads the output register.
// The slave side accepts one request at a time and is ready again once the result
// is loaded; a stalled result stream holds a finished result back in S_FIN while
// the output register is still occupied. The result sits in an output register,
// so the next request is taken while the previous result still waits.
// Configuration is written through the plain register port; the user must write it
// only while the block is idle, and the block itself does not enforce this.
`default_nettype none

module raster_position_from_time (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [rpft_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rpft_pkg::NS_W-1:0]      i_cfg_data,
    // Request stream.
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [62:0] stamp, [63] clock_on
    input  wire logic [rpft_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: [0] command
    input  wire logic                           i_s_axis_tuser,
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: [10:0] line_index, [30:11] pixel_index, [31] vblank, [32] hblank,
    // [33] vsync, [34] hsync, [35] active, [67:36] until_vsync,
    // [99:68] until_vblank, [103:100] zero
    output logic [rpft_pkg::M_DATA_W-1:0]       o_m_axis_tdata
);

    localparam int unsigned NS_W    = rpft_pkg::NS_W;
    localparam int unsigned LINES_W = rpft_pkg::LINES_W;
    localparam int unsigned FRAME_W = rpft_pkg::FRAME_W;
    localparam int unsigned STAMP_W = rpft_pkg::STAMP_W;
    localparam int unsigned UNTIL_W = rpft_pkg::UNTIL_W;
    localparam int unsigned DIVD_W  = rpft_pkg::DIVD_W;
    localparam int unsigned STEP_W  = rpft_pkg::STEP_W;

    rpft_pkg::t_cfg                 cfg;
    rpft_pkg::t_div_req             div_req;
    logic                           div_done;
    logic [DIVD_W-1:0]              div_quot;
    logic [FRAME_W-1:0]             div_rem;

    rpft_pkg::t_state               r_state;
    rpft_pkg::t_state               n_state;

    logic [STAMP_W-1:0]             r_origin;
    logic [STAMP_W-1:0]             r_elapsed;
    logic                           r_zero;
    logic [1:0]                     r_mul_sel;
    logic [FRAME_W-1:0]             r_frame;
    logic [FRAME_W-1:0]             r_vact_t;
    logic [FRAME_W-1:0]             r_vsync_t;
    logic [FRAME_W-1:0]             r_tif;
    logic [LINES_W-1:0]             r_line;
    logic [NS_W-1:0]                r_til;
    logic [NS_W-1:0]                r_pixel;
    logic                           r_out_valid;
    logic [rpft_pkg::M_BITS-1:0]    r_out_data;

    logic                           s_accept;
    logic [STAMP_W-1:0]             in_stamp;
    logic                           in_clock_on;
    logic                           timing_ok;
    logic [LINES_W-1:0]             mul_b;
    logic [FRAME_W-1:0]             mul_p;
    logic                           out_free;
    logic                           f_vb;
    logic                           f_vs;
    logic                           f_hwin;
    logic                           f_hb;
    logic                           f_hs;
    logic                           f_act;
    logic [UNTIL_W-1:0]             f_until_vs;
    logic [UNTIL_W-1:0]             f_until_vb;
    logic [rpft_pkg::M_BITS-1:0]    f_result;

    // Time from the point t within the frame to the next occurrence of mark.
    function automatic logic [UNTIL_W-1:0] time_until(
        input logic [FRAME_W-1:0] mark,
        input logic [FRAME_W-1:0] t,
        input logic [FRAME_W-1:0] frame
    );
        logic [UNTIL_W-1:0] res;
        if (t < mark) begin
            res = UNTIL_W'(mark) - UNTIL_W'(t);
        end else begin
            res = UNTIL_W'(frame) - UNTIL_W'(t) + UNTIL_W'(mark);
        end
        return res;
    endfunction

    rpft_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rpft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // Request fields and handshake.
    assign in_stamp        = i_s_axis_tdata[STAMP_W-1:0];
    assign in_clock_on     = i_s_axis_tdata[STAMP_W];
    assign o_s_axis_tready = (r_state == rpft_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign timing_ok       = (cfg.line_ns != '0) && (cfg.frame_lines != '0);
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Shared multiplier: line_ns times a line count.
    always_comb begin
        case (r_mul_sel)
            2'd0:    mul_b = cfg.frame_lines;
            2'd1:    mul_b = cfg.vactive_lines;
            default: mul_b = cfg.vsync_start_line;
        endcase
        mul_p = FRAME_W'(cfg.line_ns) * FRAME_W'(mul_b);
    end

    // Next state and divider requests.
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.steps    = '0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            rpft_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (i_s_axis_tuser == rpft_pkg::CMD_RESTART || !in_clock_on
                            || !timing_ok) begin
                        n_state = rpft_pkg::S_FIN;
                    end else begin
                        n_state = rpft_pkg::S_MUL;
                    end
                end
            end
            rpft_pkg::S_MUL: begin
                if (r_mul_sel == 2'd2) begin
                    n_state = rpft_pkg::S_MOD_GO;
                end
            end
            rpft_pkg::S_MOD_GO: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(STAMP_W);
                div_req.dividend = {r_elapsed, {(DIVD_W - STAMP_W){1'b0}}};
                div_req.divisor  = r_frame;
                n_state          = rpft_pkg::S_MOD;
            end
            rpft_pkg::S_MOD: begin
                if (div_done) begin
                    n_state = rpft_pkg::S_LINE_GO;
                end
            end
            rpft_pkg::S_LINE_GO: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(FRAME_W);
                div_req.dividend = {r_tif, {(DIVD_W - FRAME_W){1'b0}}};
                div_req.divisor  = FRAME_W'(cfg.line_ns);
                n_state          = rpft_pkg::S_LINE;
            end
            rpft_pkg::S_LINE: begin
                if (div_done) begin
                    n_state = rpft_pkg::S_PIX_GO;
                end
            end
            rpft_pkg::S_PIX_GO: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(NS_W);
                div_req.dividend = {r_til, {(DIVD_W - NS_W){1'b0}}};
                div_req.divisor  = FRAME_W'(cfg.pixel_ns);
                n_state          = rpft_pkg::S_PIX;
            end
            rpft_pkg::S_PIX: begin
                if (div_done) begin
                    n_state = rpft_pkg::S_FIN;
                end
            end
            rpft_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = rpft_pkg::S_IDLE;
                end
            end
            default: n_state = rpft_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Clock origin and the zero-result flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_zero   <= 1'b0;
        end else if (s_accept) begin
            r_zero <= (i_s_axis_tuser == rpft_pkg::CMD_RESTART) || !in_clock_on
                      || !timing_ok;
            if (i_s_axis_tuser == rpft_pkg::CMD_RESTART) begin
                r_origin <= in_stamp;
            end
        end
    end

    // Multiplier step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_sel <= '0;
        end else if (r_state == rpft_pkg::S_MUL) begin
            r_mul_sel <= (r_mul_sel == 2'd2) ? 2'd0 : r_mul_sel + 2'd1;
        end
    end

    // Datapath registers; elapsed time saturates at zero before the origin.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_elapsed <= (in_stamp >= r_origin) ? in_stamp - r_origin : '0;
        end
        if (r_state == rpft_pkg::S_MUL) begin
            case (r_mul_sel)
                2'd0:    r_frame   <= mul_p;
                2'd1:    r_vact_t  <= mul_p;
                default: r_vsync_t <= mul_p;
            endcase
        end
        if (r_state == rpft_pkg::S_MOD && div_done) begin
            r_tif <= div_rem;
        end
        if (r_state == rpft_pkg::S_LINE && div_done) begin
            r_line <= div_quot[LINES_W-1:0];
            r_til  <= div_rem[NS_W-1:0];
        end
        if (r_state == rpft_pkg::S_PIX && div_done) begin
            r_pixel <= (cfg.pixel_ns != '0) ? div_quot[NS_W-1:0] : '0;
        end
    end

    // Flags and distances from the final position.
    always_comb begin
        f_vb       = r_line >= cfg.vactive_lines;
        f_vs       = (r_line >= cfg.vsync_start_line) && (r_line < cfg.vsync_end_line);
        f_hwin     = (r_til >= cfg.hsync_start_ns) && (r_til < cfg.hsync_end_ns);
        f_hb       = !f_vb && f_hwin;
        f_hs       = !f_vs && f_hwin;
        f_act      = !(f_hb || f_vb);
        f_until_vs = time_until(r_vsync_t, r_tif, r_frame);
        f_until_vb = time_until(r_vact_t, r_tif, r_frame);
        f_result   = {f_until_vb, f_until_vs, f_act, f_hs, f_vs, f_hb, f_vb,
                      r_pixel, r_line};
    end

    // Output register; a finished result waits in it for the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rpft_pkg::S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rpft_pkg::S_FIN && out_free) begin
            r_out_data <= r_zero ? '0 : f_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(rpft_pkg::M_DATA_W - rpft_pkg::M_BITS){1'b0}}, r_out_data};

    // A restart request latches its stamp as the new origin.
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tuser == rpft_pkg::CMD_RESTART)
            |=> (r_origin == $past(in_stamp)))
        else $error("restart did not latch the origin");

    // A finished result waits while the output register is still occupied.
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpft_pkg::S_FIN && r_out_valid && !i_m_axis_tready)
            |=> (r_state == rpft_pkg::S_FIN && r_out_valid))
        else $error("result overwrote a pending output");

    // The divider is started only from its launch states.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_state == rpft_pkg::S_MOD_GO
            || r_state == rpft_pkg::S_LINE_GO || r_state == rpft_pkg::S_PIX_GO))
        else $error("divider started outside a launch state");

endmodule

`default_nettype wire
